[sv/rtsc_pkg.sv]
package rtsc_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned ValW = 7;

  localparam logic [PosW-1:0] LEN_SHORT = PosW'(20);
  localparam logic [PosW-1:0] LEN_LONG  = PosW'(25);
  localparam logic [PosW-1:0] POS_SAT   = PosW'(26);
  localparam logic [PosW-1:0] POS_SUFFIX = PosW'(19);

  localparam logic [ValW-1:0] MAX_HOUR = ValW'(23);
  localparam logic [ValW-1:0] MAX_MIN  = ValW'(59);
  localparam logic [ValW-1:0] MAX_MONTH = ValW'(12);

  localparam logic [7:0] CH_ZULU  = 8'h5A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // parsed timestamp; the year is kept as four decimal digits, most significant first
  typedef struct packed {
    logic [PosW-1:0]      pos;
    logic [3:0][3:0]      year;
    logic [ValW-1:0]      month;
    logic [ValW-1:0]      day;
    logic [ValW-1:0]      hour;
    logic [ValW-1:0]      minute;
    logic [ValW-1:0]      second;
    logic [ValW-1:0]      zone_hour;
    logic [ValW-1:0]      zone_minute;
    logic                 zulu;
    logic                 sign;
    logic                 ferr;
  } fields_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

[sv/rtsc_parse.sv]
module rtsc_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [7:0]           char_byte,
  input  logic                 last_byte,
  output rtsc_pkg::fields_t    fld_nxt
);

  rtsc_pkg::fields_t fld_r;
  logic              is_digit;
  logic [3:0]        dig;

  function automatic logic [rtsc_pkg::ValW-1:0] acc10(
    input logic [rtsc_pkg::ValW-1:0] acc,
    input logic [3:0]                d
  );
    logic [rtsc_pkg::ValW-1:0] s;
    s = (acc << 3) + (acc << 1) + rtsc_pkg::ValW'(d);
    return s;
  endfunction

  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign dig      = char_byte[3:0];

  always_comb begin
    fld_nxt = fld_r;
    unique case (fld_r.pos)
      5'd0, 5'd1, 5'd2, 5'd3: begin
        if (is_digit) fld_nxt.year[fld_r.pos[1:0]] = dig;
        else fld_nxt.ferr = 1'b1;
      end
      5'd5, 5'd6: begin
        if (is_digit) fld_nxt.month = acc10(fld_r.month, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd8, 5'd9: begin
        if (is_digit) fld_nxt.day = acc10(fld_r.day, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd11, 5'd12: begin
        if (is_digit) fld_nxt.hour = acc10(fld_r.hour, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd14, 5'd15: begin
        if (is_digit) fld_nxt.minute = acc10(fld_r.minute, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd17, 5'd18: begin
        if (is_digit) fld_nxt.second = acc10(fld_r.second, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd20, 5'd21: begin
        if (is_digit) fld_nxt.zone_hour = acc10(fld_r.zone_hour, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd23, 5'd24: begin
        if (is_digit) fld_nxt.zone_minute = acc10(fld_r.zone_minute, dig);
        else fld_nxt.ferr = 1'b1;
      end
      5'd4, 5'd7: begin
        if (char_byte != rtsc_pkg::CH_DASH) fld_nxt.ferr = 1'b1;
      end
      5'd10: begin
        if (char_byte != rtsc_pkg::CH_T) fld_nxt.ferr = 1'b1;
      end
      5'd13, 5'd16, 5'd22: begin
        if (char_byte != rtsc_pkg::CH_COLON) fld_nxt.ferr = 1'b1;
      end
      rtsc_pkg::POS_SUFFIX: begin
        if (char_byte == rtsc_pkg::CH_ZULU) fld_nxt.zulu = 1'b1;
        else if (char_byte == rtsc_pkg::CH_PLUS || char_byte == rtsc_pkg::CH_DASH)
          fld_nxt.sign = 1'b1;
        else fld_nxt.ferr = 1'b1;
      end
      // too long
      default: fld_nxt.ferr = 1'b1;
    endcase
    if (fld_r.pos < rtsc_pkg::POS_SAT) fld_nxt.pos = fld_r.pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r <= '0;
    end else if (en) begin
      if (last_byte) begin
        fld_r <= '0;
      end else begin
        fld_r <= fld_nxt;
      end
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    fld_r.pos <= rtsc_pkg::POS_SAT)
    else $error("byte position past saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && last_byte |=> fld_r.pos == '0 && !fld_r.ferr && !fld_r.zulu && !fld_r.sign)
    else $error("state not cleared after final byte");

endmodule

[sv/rtsc_judge.sv]
module rtsc_judge (
  input  rtsc_pkg::fields_t fld,
  output logic              ok
);

  logic [3:0] m4;
  logic       leap;
  logic [5:0] max_day;
  logic       ranges_ok;
  logic       form_ok;

  assign m4 = fld.month[3:0];

  // two-digit value mod 4 equals (2*tens + ones) mod 4
  always_comb begin
    if (fld.year[2] == 4'd0 && fld.year[3] == 4'd0) begin
      leap = (2'({fld.year[0][0], 1'b0}) + fld.year[1][1:0]) == 2'd0;
    end else begin
      leap = (2'({fld.year[2][0], 1'b0}) + fld.year[3][1:0]) == 2'd0;
    end
  end

  assign max_day = {1'b0, rtsc_pkg::month_days(m4)} + 6'((m4 == 4'd2) && leap);

  assign ranges_ok = (fld.year != '0)
                  && (fld.month != '0) && (fld.month <= rtsc_pkg::MAX_MONTH)
                  && (fld.hour <= rtsc_pkg::MAX_HOUR)
                  && (fld.minute <= rtsc_pkg::MAX_MIN)
                  && (fld.second <= rtsc_pkg::MAX_MIN)
                  && (fld.day != '0) && (fld.day <= rtsc_pkg::ValW'(max_day));

  always_comb begin
    if (fld.pos == rtsc_pkg::LEN_SHORT) begin
      form_ok = fld.zulu;
    end else if (fld.pos == rtsc_pkg::LEN_LONG) begin
      form_ok = fld.sign && (fld.zone_hour <= rtsc_pkg::MAX_HOUR)
             && (fld.zone_minute <= rtsc_pkg::MAX_MIN);
    end else begin
      form_ok = 1'b0;
    end
  end

  assign ok = !fld.ferr && ranges_ok && form_ok;

endmodule

[sv/rfc3339_timestamp_check.sv]
// out_valid is registered, raised when the final byte leaves the input stage
// throughput: one byte per cycle; bytes keep flowing while a result waits,
//   only a final byte stalls behind a result that has not been taken
// reset (rst_n low, synchronous): pipeline empties, parser state clears,
//   the next byte starts a new string
module rfc3339_timestamp_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_timestamp_valid
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic              out_ts_r;
  logic              out_free;
  logic              s1_go;
  logic              in_take;
  logic              ok;
  rtsc_pkg::fields_t fld_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_char_byte;
      s1_last_r <= in_last_byte;
    end
  end

  rtsc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_go),
    .char_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .fld_nxt   (fld_nxt)
  );

  rtsc_judge u_judge (
    .fld (fld_nxt),
    .ok  (ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_ts_r <= ok;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_timestamp_valid = out_ts_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked final byte");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> !out_valid_r || $past(s1_go && s1_last_r))
    else $error("result raised without a final byte");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef enum logic [1:0] {ZONE_ZULU, ZONE_PLUS, ZONE_MINUS} zone_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_timestamp_valid;

  rfc3339_timestamp_check dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_byte        (in_char_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_timestamp_valid (out_timestamp_valid)
  );

  always #6 clk = ~clk;

  // parser state mirrored by the predictor
  logic [4:0]  cur_pos;
  logic [13:0] cur_year;
  logic [6:0]  cur_month, cur_day, cur_hour, cur_minute, cur_second;
  logic [6:0]  cur_zone_hour, cur_zone_minute;
  logic        cur_zulu, cur_sign, cur_ferr;

  int days_in_month [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic stamp_ok_q [$];
  logic want_ok;
  int   mismatches = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  int   bytes_sent = 0;
  int   gap_pct;
  int   stall_pct;

  // text under construction, sent one transfer per byte
  logic [7:0] txt [0:47];
  int         txt_len;

  task automatic clear_parser();
    cur_pos = '0;
    cur_year = '0;
    cur_month = '0;
    cur_day = '0;
    cur_hour = '0;
    cur_minute = '0;
    cur_second = '0;
    cur_zone_hour = '0;
    cur_zone_minute = '0;
    cur_zulu = 1'b0;
    cur_sign = 1'b0;
    cur_ferr = 1'b0;
  endtask

  function automatic logic [6:0] shift_digit(input logic [6:0] acc, input logic [7:0] b);
    return 7'(int'(acc) * 10 + int'(b) - int'(CH_ZERO));
  endfunction

  function automatic logic calendar_ok();
    int maxd;
    if (cur_year == 0 || cur_month < 1 || cur_month > rtsc_pkg::MAX_MONTH) return 1'b0;
    if (cur_hour > rtsc_pkg::MAX_HOUR || cur_minute > rtsc_pkg::MAX_MIN
        || cur_second > rtsc_pkg::MAX_MIN) return 1'b0;
    maxd = days_in_month[cur_month];
    if (cur_month == 2 && cur_year % 4 == 0 && (cur_year % 100 != 0 || cur_year % 400 == 0))
      maxd++;
    return cur_day >= 1 && cur_day <= maxd;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    logic dig;
    logic ok;
    dig = (b >= CH_ZERO && b <= CH_NINE);
    case (cur_pos)
      0, 1, 2, 3: begin
        if (dig) cur_year = 14'(int'(cur_year) * 10 + int'(b) - int'(CH_ZERO));
        else cur_ferr = 1'b1;
      end
      5, 6: if (dig) cur_month = shift_digit(cur_month, b); else cur_ferr = 1'b1;
      8, 9: if (dig) cur_day = shift_digit(cur_day, b); else cur_ferr = 1'b1;
      11, 12: if (dig) cur_hour = shift_digit(cur_hour, b); else cur_ferr = 1'b1;
      14, 15: if (dig) cur_minute = shift_digit(cur_minute, b); else cur_ferr = 1'b1;
      17, 18: if (dig) cur_second = shift_digit(cur_second, b); else cur_ferr = 1'b1;
      20, 21: if (dig) cur_zone_hour = shift_digit(cur_zone_hour, b); else cur_ferr = 1'b1;
      23, 24: if (dig) cur_zone_minute = shift_digit(cur_zone_minute, b); else cur_ferr = 1'b1;
      4, 7: if (b != rtsc_pkg::CH_DASH) cur_ferr = 1'b1;
      10: if (b != rtsc_pkg::CH_T) cur_ferr = 1'b1;
      13, 16, 22: if (b != rtsc_pkg::CH_COLON) cur_ferr = 1'b1;
      rtsc_pkg::POS_SUFFIX: begin
        if (b == rtsc_pkg::CH_ZULU) cur_zulu = 1'b1;
        else if (b == rtsc_pkg::CH_PLUS || b == rtsc_pkg::CH_DASH) cur_sign = 1'b1;
        else cur_ferr = 1'b1;
      end
      default: cur_ferr = 1'b1;
    endcase
    if (cur_pos < rtsc_pkg::POS_SAT) cur_pos++;
    if (lst) begin
      ok = !cur_ferr && calendar_ok();
      if (ok) begin
        if (cur_pos == rtsc_pkg::LEN_SHORT) ok = cur_zulu;
        else if (cur_pos == rtsc_pkg::LEN_LONG)
          ok = cur_sign && cur_zone_hour <= rtsc_pkg::MAX_HOUR
               && cur_zone_minute <= rtsc_pkg::MAX_MIN;
        else ok = 1'b0;
      end
      stamp_ok_q.push_back(ok);
      clear_parser();
    end
  endtask

  // one transfer; the sender may idle first
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_byte <= b;
    in_last_byte <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_byte(b, lst);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < txt_len; i++) send_byte(txt[i], i == txt_len - 1);
  endtask

  task automatic put_char(input logic [7:0] c);
    txt[txt_len] = c;
    txt_len++;
  endtask

  task automatic put_num(input int v, input int n);
    int dv;
    dv = 1;
    for (int i = 1; i < n; i++) dv *= 10;
    for (int i = 0; i < n; i++) begin
      put_char(8'(int'(CH_ZERO) + (v / dv) % 10));
      dv /= 10;
    end
  endtask

  task automatic build_stamp(input int y, input int mo, input int d, input int h,
                             input int mi, input int s, input zone_t zk,
                             input int zh, input int zm);
    txt_len = 0;
    put_num(y, 4);
    put_char(rtsc_pkg::CH_DASH);
    put_num(mo, 2);
    put_char(rtsc_pkg::CH_DASH);
    put_num(d, 2);
    put_char(rtsc_pkg::CH_T);
    put_num(h, 2);
    put_char(rtsc_pkg::CH_COLON);
    put_num(mi, 2);
    put_char(rtsc_pkg::CH_COLON);
    put_num(s, 2);
    if (zk == ZONE_ZULU) begin
      put_char(rtsc_pkg::CH_ZULU);
    end else begin
      put_char(zk == ZONE_PLUS ? rtsc_pkg::CH_PLUS : rtsc_pkg::CH_DASH);
      put_num(zh, 2);
      put_char(rtsc_pkg::CH_COLON);
      put_num(zm, 2);
    end
  endtask

  task automatic send_stamp(input int y, input int mo, input int d, input int h,
                            input int mi, input int s, input zone_t zk,
                            input int zh, input int zm);
    build_stamp(y, mo, d, h, mi, s, zk, zh, zm);
    send_text();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stamp_ok_q.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_field(input int top);
    if ($urandom_range(6) == 0) return $urandom_range(99, top - 3);
    return $urandom_range(top);
  endfunction

  task automatic build_random_text();
    int r, y, mo, d, n;
    zone_t zk;
    r = $urandom_range(9);
    case (r)
      0: y = 0;
      1: y = $urandom_range(24) * 100;
      2: y = $urandom_range(2499) * 4;
      default: y = $urandom_range(9999, 1);
    endcase
    mo = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
    r = $urandom_range(9);
    d = (r < 6) ? $urandom_range(28, 1) : (r < 9) ? $urandom_range(32, 27) : $urandom_range(99);
    zk = zone_t'($urandom_range(2));
    build_stamp(y, mo, d, pick_field(23), pick_field(59), pick_field(59), zk,
                pick_field(23), pick_field(59));
    r = $urandom_range(99);
    if (r >= 60 && r < 78) begin
      txt[$urandom_range(txt_len - 1)] = 8'($urandom);
    end else if (r >= 78 && r < 90) begin
      if ($urandom_range(1) == 1) begin
        txt_len = $urandom_range(txt_len - 1, 1);
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) put_char(8'($urandom));
      end
    end else if (r >= 90) begin
      txt_len = 0;
      n = $urandom_range(30, 1);
      repeat (n) put_char(8'($urandom));
    end
  endtask

  task automatic test_calendar();
    send_stamp(2024, 2, 29, 23, 59, 59, ZONE_ZULU, 0, 0);
    send_stamp(2023, 2, 29, 12, 0, 0, ZONE_ZULU, 0, 0);
    send_stamp(1900, 2, 29, 12, 0, 0, ZONE_ZULU, 0, 0);
    send_stamp(2000, 2, 29, 12, 0, 0, ZONE_ZULU, 0, 0);
    send_stamp(0, 1, 1, 0, 0, 0, ZONE_ZULU, 0, 0);
    send_stamp(9999, 12, 31, 23, 59, 59, ZONE_PLUS, 23, 59);
    send_stamp(2021, 0, 10, 1, 2, 3, ZONE_ZULU, 0, 0);
    send_stamp(2021, 13, 10, 1, 2, 3, ZONE_ZULU, 0, 0);
    send_stamp(2021, 5, 0, 1, 2, 3, ZONE_ZULU, 0, 0);
    send_stamp(2021, 4, 31, 1, 2, 3, ZONE_ZULU, 0, 0);
    send_stamp(2021, 99, 99, 1, 2, 3, ZONE_ZULU, 0, 0);
  endtask

  task automatic test_clock_fields();
    send_stamp(2020, 6, 15, 24, 0, 0, ZONE_ZULU, 0, 0);
    send_stamp(2020, 6, 15, 23, 60, 0, ZONE_ZULU, 0, 0);
    send_stamp(2020, 6, 15, 23, 59, 60, ZONE_ZULU, 0, 0);
    send_stamp(2020, 6, 15, 0, 0, 0, ZONE_ZULU, 0, 0);
  endtask

  task automatic test_zone_offset();
    send_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 24, 0);
    send_stamp(2020, 6, 15, 8, 30, 0, ZONE_MINUS, 23, 60);
    send_stamp(2020, 6, 15, 8, 30, 0, ZONE_MINUS, 0, 0);
    send_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 99, 99);
  endtask

  task automatic test_format();
    // sign suffix cut to the short length
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 1, 0);
    txt_len = int'(rtsc_pkg::LEN_SHORT);
    send_text();
    // zulu followed by a well-formed offset
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    put_num(1, 2);
    put_char(rtsc_pkg::CH_COLON);
    put_num(0, 2);
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    txt[10] = 8'h74;
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    txt[5] = 8'h00;
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_MINUS, 5, 30);
    txt[0] = 8'hFF;
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    txt[13] = rtsc_pkg::CH_DASH;
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    txt[19] = 8'h7A;
    send_text();
  endtask

  task automatic test_length();
    txt_len = 0;
    put_char(CH_ZERO);
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    txt_len = 19;
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_ZULU, 0, 0);
    put_char(CH_ZERO);
    send_text();
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 5, 30);
    put_char(CH_ZERO);
    send_text();
    // well past the saturation point of the position counter
    build_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 5, 30);
    repeat (15) put_char(CH_NINE);
    send_text();
    send_stamp(2020, 6, 15, 8, 30, 0, ZONE_PLUS, 5, 30);
  endtask

  task automatic test_pause_until_drained();
    send_stamp(1996, 2, 29, 10, 10, 10, ZONE_ZULU, 0, 0);
    wait_drained();
    send_stamp(1997, 2, 28, 10, 10, 10, ZONE_MINUS, 12, 45);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int gap, input int stall);
    int target;
    gap_pct = gap;
    stall_pct = stall;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_random_text();
      send_text();
    end
    wait_drained();
  endtask

  // receiver side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (stamp_ok_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("result %0d: none expected, got timestamp_valid=%0b",
                   results_seen, out_timestamp_valid);
      end else begin
        want_ok = stamp_ok_q.pop_front();
        if (out_timestamp_valid !== want_ok) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result %0d: timestamp_valid expected %0b, got %0b",
                     results_seen, want_ok, out_timestamp_valid);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    clear_parser();
    gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = 8'h00;
    in_last_byte = 1'b0;
    out_stall = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_calendar();
    test_clock_fields();
    test_zone_offset();
    test_format();
    test_length();
    test_pause_until_drained();
    test_random_traffic(285, 0, 0);
    test_random_traffic(285, 88, 0);
    test_random_traffic(285, 0, 88);
    test_random_traffic(285, 22, 22);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
